// ===== src/assert_macros.svh =====
// assertion macros for the segment pool allocator
// expects clk_i and rst_ni in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SPA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("segment pool allocator assertion failed");
`define SPA_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("segment pool allocator forbidden condition");
`else
`define SPA_ASSERT(lbl, prop)
`define SPA_NEVER(lbl, expr)
`endif
`endif

// ===== src/spa_pkg.sv =====
// types and codes of the segment pool allocator
// no dependencies
`default_nettype none
package spa_pkg;

  localparam int AW = 25;
  localparam int LW = 26;
  localparam int EW = 32;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_RESIZE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    FIT_BEST  = 2'd0,
    FIT_WORST = 2'd1,
    FIT_FIRST = 2'd2
  } fit_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NOFIT   = 3'd2,
    ST_NONODE  = 3'd3,
    ST_UNKNOWN = 3'd4,
    ST_ALREADY = 3'd5
  } status_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_FD_RD,
    S_FD_EV,
    S_FOUND,
    S_GR_EV,
    S_SH_EV,
    S_SH_NEW,
    S_CH_RD,
    S_CH_EV,
    S_CH_END,
    S_AL_GOT,
    S_AL_SPLIT,
    S_AL_WRC,
    S_AL_FIN,
    S_MV_RD,
    S_MV_EV,
    S_SP_RD,
    S_SP_EV,
    S_LK_RD,
    S_LK_WR,
    S_RL_BEGIN,
    S_RL_P,
    S_RL_N0,
    S_RL_N,
    S_WR_CR,
    S_FINISH
  } state_e;

  typedef struct packed {
    status_e         status;
    logic [AW-1:0]   result_address;
    logic            moved;
    logic [LW-1:0]   old_length;
    logic [LW-1:0]   free_bytes;
    logic [EW-1:0]   error_count;
  } result_t;

endpackage
`default_nettype wire

// ===== src/spa_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module spa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(DEPTH)-1:0] waddr_i,
  input  wire [WIDTH-1:0]         wdata_i,
  input  wire [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== src/spa_engine.sv =====
// command sequencer: list walks, fit search, split, merge and resize
// depends on spa_pkg, drives the node ram
`default_nettype none
module spa_engine #(
  parameter int NODE_COUNT = 1024,
  parameter longint unsigned POOL_BYTES = 33554432
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start,
  output logic                         busy,
  input  wire [1:0]                    command_i,
  input  wire [spa_pkg::AW-1:0]        block_address_i,
  input  wire [spa_pkg::LW-1:0]        request_size_i,
  input  wire [1:0]                    fit_mode_i,
  output logic                         ram_we_o,
  output logic [$clog2(NODE_COUNT)-1:0] ram_waddr_o,
  output logic [spa_pkg::AW+spa_pkg::LW+2+2*$clog2(NODE_COUNT)-1:0] ram_wdata_o,
  output logic [$clog2(NODE_COUNT)-1:0] ram_raddr_o,
  input  wire [spa_pkg::AW+spa_pkg::LW+2+2*$clog2(NODE_COUNT)-1:0] ram_rdata_i,
  output logic                         done_o,
  output spa_pkg::result_t             result_o
);
  import spa_pkg::*;

  localparam int IW = $clog2(NODE_COUNT);
  localparam logic [IW-1:0] LAST = IW'(NODE_COUNT - 1);

  typedef struct packed {
    logic [AW-1:0] start;
    logic [LW-1:0] len;
    logic          is_free;
    logic          in_use;
    logic [IW-1:0] prev;
    logic [IW-1:0] nxt;
  } node_t;

  state_e state_q, state_d, al_ret_q, al_ret_d, sp_ret_q, sp_ret_d, lk_ret_q, lk_ret_d;
  logic [1:0]    cmd_q, cmd_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [LW-1:0] size_q, size_d;
  logic [IW-1:0] head_q, head_d, tail_q, tail_d;
  logic [LW-1:0] free_q, free_d;
  logic [EW-1:0] reject_q, reject_d;
  logic [IW-1:0] cur_q, cur_d, cnt_q, cnt_d;
  logic          pv_q, pv_d;
  logic [IW-1:0] pidx_q, pidx_d;
  node_t         prec_q, prec_d;
  logic [IW-1:0] ci_q, ci_d;
  node_t         cr_q, cr_d;
  logic [IW-1:0] sp_idx_q, sp_idx_d;
  logic [IW-1:0] lk_idx_q, lk_idx_d, lk_val_q, lk_val_d;
  logic          lk_next_q, lk_next_d;
  status_e       status_q, status_d;
  logic [AW-1:0] res_addr_q, res_addr_d;
  logic          moved_q, moved_d;
  logic [LW-1:0] old_len_q, old_len_d;
  logic [IW-1:0] clr_idx_q, clr_idx_d;
  logic          done_q, done_d;
  result_t       out_q, out_d;

  node_t         rd, nw;
  logic [LW-1:0] grow_g, shrink_d;
  logic          take, first_hit, walk_end;

  assign rd       = node_t'(ram_rdata_i);
  assign grow_g   = size_q - cr_q.len;
  assign shrink_d = cr_q.len - size_q;
  assign walk_end = (cur_q == head_q) || (cnt_q == LAST);

  always_comb begin
    first_hit = 1'b0;
    if (fit_mode_i == FIT_WORST) begin
      take = rd.is_free && (!pv_q || rd.len > prec_q.len);
    end else if (fit_mode_i == FIT_FIRST) begin
      take      = 1'b0;
      first_hit = rd.is_free && rd.len >= size_q;
    end else begin
      take = rd.is_free && rd.len >= size_q && (!pv_q || rd.len < prec_q.len);
    end
  end

  always_comb begin
    state_d = state_q; al_ret_d = al_ret_q; sp_ret_d = sp_ret_q; lk_ret_d = lk_ret_q;
    cmd_d = cmd_q; addr_d = addr_q; size_d = size_q;
    head_d = head_q; tail_d = tail_q; free_d = free_q; reject_d = reject_q;
    cur_d = cur_q; cnt_d = cnt_q; pv_d = pv_q; pidx_d = pidx_q; prec_d = prec_q;
    ci_d = ci_q; cr_d = cr_q; sp_idx_d = sp_idx_q;
    lk_idx_d = lk_idx_q; lk_val_d = lk_val_q; lk_next_d = lk_next_q;
    status_d = status_q; res_addr_d = res_addr_q; moved_d = moved_q; old_len_d = old_len_q;
    clr_idx_d = clr_idx_q;
    done_d = 1'b0;
    out_d = out_q;
    ram_we_o = 1'b0;
    ram_waddr_o = ci_q;
    ram_raddr_o = cur_q;
    nw = cr_q;

    unique case (state_q)
      S_CLEAR: begin
        ram_we_o = 1'b1;
        ram_waddr_o = clr_idx_q;
        nw = '0;
        if (clr_idx_q == '0) begin
          nw.len = LW'(POOL_BYTES);
          nw.is_free = 1'b1;
          nw.in_use = 1'b1;
        end
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_d = command_i;
          addr_d = block_address_i;
          size_d = request_size_i;
          status_d = ST_OK;
          res_addr_d = '0;
          moved_d = 1'b0;
          old_len_d = '0;
          cur_d = tail_q;
          cnt_d = '0;
          pv_d = 1'b0;
          unique case (command_i)
            CMD_ALLOC: begin
              al_ret_d = S_FINISH;
              if (request_size_i == '0) begin
                status_d = ST_ZERO;
                state_d = S_FINISH;
              end else begin
                state_d = S_CH_RD;
              end
            end
            CMD_FREE, CMD_RESIZE: state_d = S_FD_RD;
            default: state_d = S_FINISH;
          endcase
        end
      end
      S_FD_RD: state_d = S_FD_EV;
      S_FD_EV: begin
        if (rd.start == addr_q) begin
          ci_d = cur_q;
          cr_d = rd;
          state_d = S_FOUND;
        end else if (walk_end) begin
          status_d = ST_UNKNOWN;
          state_d = S_FINISH;
        end else begin
          cur_d = rd.prev;
          cnt_d = cnt_q + 1'b1;
          state_d = S_FD_RD;
        end
      end
      S_FOUND: begin
        ram_raddr_o = cr_q.nxt;
        cur_d = tail_q;
        cnt_d = '0;
        pv_d = 1'b0;
        sp_idx_d = '0;
        if (cr_q.is_free) begin
          status_d = ST_ALREADY;
          state_d = S_FINISH;
        end else if (cmd_q == CMD_FREE || size_q == '0) begin
          state_d = S_RL_BEGIN;
        end else if (size_q > cr_q.len) begin
          al_ret_d = S_MV_RD;
          state_d = (ci_q != tail_q) ? S_GR_EV : S_CH_RD;
        end else if (size_q < cr_q.len) begin
          sp_ret_d = S_SH_NEW;
          state_d = (ci_q != tail_q) ? S_SH_EV : S_SP_RD;
        end else begin
          res_addr_d = cr_q.start;
          state_d = S_FINISH;
        end
      end
      S_GR_EV: begin
        if (rd.is_free && rd.len >= grow_g) begin
          free_d = free_q - grow_g;
          res_addr_d = cr_q.start;
          cr_d.len = size_q;
          nw = rd;
          nw.start = rd.start + AW'(grow_g);
          nw.len = rd.len - grow_g;
          ram_we_o = 1'b1;
          ram_waddr_o = cr_q.nxt;
          state_d = S_WR_CR;
          if (nw.len == '0) begin
            nw.in_use = 1'b0;
            nw.is_free = 1'b0;
            cr_d.nxt = rd.nxt;
            if (cr_q.nxt == tail_q) begin
              tail_d = ci_q;
            end else begin
              lk_idx_d = rd.nxt;
              lk_val_d = ci_q;
              lk_next_d = 1'b0;
              lk_ret_d = S_WR_CR;
              state_d = S_LK_RD;
            end
          end
        end else begin
          state_d = S_CH_RD;
        end
      end
      S_SH_EV: begin
        if (rd.is_free) begin
          nw = rd;
          nw.start = rd.start - AW'(shrink_d);
          nw.len = rd.len + shrink_d;
          ram_we_o = 1'b1;
          ram_waddr_o = cr_q.nxt;
          cr_d.len = size_q;
          free_d = free_q + shrink_d;
          res_addr_d = cr_q.start;
          state_d = S_WR_CR;
        end else begin
          state_d = S_SP_RD;
        end
      end
      S_SH_NEW: begin
        nw.start = cr_q.start + AW'(size_q);
        nw.len = shrink_d;
        nw.is_free = 1'b1;
        nw.in_use = 1'b1;
        nw.prev = ci_q;
        nw.nxt = cr_q.nxt;
        ram_we_o = 1'b1;
        ram_waddr_o = sp_idx_q;
        cr_d.nxt = sp_idx_q;
        cr_d.len = size_q;
        free_d = free_q + shrink_d;
        res_addr_d = cr_q.start;
        state_d = S_WR_CR;
        if (ci_q != tail_q) begin
          lk_idx_d = cr_q.nxt;
          lk_val_d = sp_idx_q;
          lk_next_d = 1'b0;
          lk_ret_d = S_WR_CR;
          state_d = S_LK_RD;
        end else begin
          tail_d = sp_idx_q;
        end
      end
      S_CH_RD: state_d = S_CH_EV;
      S_CH_EV: begin
        if (first_hit) begin
          pidx_d = cur_q;
          prec_d = rd;
          pv_d = 1'b1;
          state_d = S_AL_GOT;
        end else begin
          if (take) begin
            pidx_d = cur_q;
            prec_d = rd;
            pv_d = 1'b1;
          end
          if (walk_end) begin
            state_d = S_CH_END;
          end else begin
            cur_d = rd.prev;
            cnt_d = cnt_q + 1'b1;
            state_d = S_CH_RD;
          end
        end
      end
      S_CH_END: begin
        if (pv_q && prec_q.len >= size_q) begin
          state_d = S_AL_GOT;
        end else begin
          status_d = ST_NOFIT;
          state_d = S_FINISH;
        end
      end
      S_AL_GOT: begin
        sp_idx_d = '0;
        if (prec_q.len == size_q) begin
          nw = prec_q;
          nw.is_free = 1'b0;
          ram_we_o = 1'b1;
          ram_waddr_o = pidx_q;
          state_d = S_AL_FIN;
        end else begin
          sp_ret_d = S_AL_SPLIT;
          state_d = S_SP_RD;
        end
      end
      S_AL_SPLIT: begin
        nw.start = prec_q.start;
        nw.len = size_q;
        nw.is_free = 1'b0;
        nw.in_use = 1'b1;
        nw.prev = prec_q.prev;
        nw.nxt = pidx_q;
        ram_we_o = 1'b1;
        ram_waddr_o = sp_idx_q;
        state_d = S_AL_WRC;
      end
      S_AL_WRC: begin
        nw = prec_q;
        nw.start = prec_q.start + AW'(size_q);
        nw.len = prec_q.len - size_q;
        nw.prev = sp_idx_q;
        ram_we_o = 1'b1;
        ram_waddr_o = pidx_q;
        if (pidx_q == head_q) begin
          head_d = sp_idx_q;
          state_d = S_AL_FIN;
        end else begin
          lk_idx_d = prec_q.prev;
          lk_val_d = sp_idx_q;
          lk_next_d = 1'b1;
          lk_ret_d = S_AL_FIN;
          state_d = S_LK_RD;
        end
      end
      S_AL_FIN: begin
        free_d = free_q - size_q;
        res_addr_d = prec_q.start;
        state_d = al_ret_q;
      end
      S_MV_RD: begin
        ram_raddr_o = ci_q;
        moved_d = 1'b1;
        old_len_d = cr_q.len;
        state_d = S_MV_EV;
      end
      S_MV_EV: begin
        cr_d = rd;
        state_d = S_RL_BEGIN;
      end
      S_SP_RD: begin
        ram_raddr_o = sp_idx_q;
        state_d = S_SP_EV;
      end
      S_SP_EV: begin
        if (!rd.in_use) begin
          state_d = sp_ret_q;
        end else if (sp_idx_q == LAST) begin
          status_d = ST_NONODE;
          state_d = S_FINISH;
        end else begin
          sp_idx_d = sp_idx_q + 1'b1;
          state_d = S_SP_RD;
        end
      end
      S_LK_RD: begin
        ram_raddr_o = lk_idx_q;
        state_d = S_LK_WR;
      end
      S_LK_WR: begin
        nw = rd;
        if (lk_next_q) begin
          nw.nxt = lk_val_q;
        end else begin
          nw.prev = lk_val_q;
        end
        ram_we_o = 1'b1;
        ram_waddr_o = lk_idx_q;
        state_d = lk_ret_q;
      end
      S_RL_BEGIN: begin
        ram_raddr_o = cr_q.prev;
        free_d = free_q + cr_q.len;
        cr_d.is_free = 1'b1;
        state_d = (ci_q != head_q) ? S_RL_P : S_RL_N0;
      end
      S_RL_P: begin
        state_d = S_RL_N0;
        if (rd.is_free) begin
          nw = cr_q;
          nw.in_use = 1'b0;
          nw.is_free = 1'b0;
          ram_we_o = 1'b1;
          ram_waddr_o = ci_q;
          cr_d = rd;
          cr_d.len = rd.len + cr_q.len;
          cr_d.nxt = cr_q.nxt;
          ci_d = cr_q.prev;
          if (ci_q == tail_q) begin
            tail_d = cr_q.prev;
          end else begin
            lk_idx_d = cr_q.nxt;
            lk_val_d = cr_q.prev;
            lk_next_d = 1'b0;
            lk_ret_d = S_RL_N0;
            state_d = S_LK_RD;
          end
        end
      end
      S_RL_N0: begin
        ram_raddr_o = cr_q.nxt;
        state_d = (ci_q != tail_q) ? S_RL_N : S_WR_CR;
      end
      S_RL_N: begin
        state_d = S_WR_CR;
        if (rd.is_free) begin
          cr_d.len = cr_q.len + rd.len;
          cr_d.nxt = rd.nxt;
          nw = rd;
          nw.in_use = 1'b0;
          nw.is_free = 1'b0;
          ram_we_o = 1'b1;
          ram_waddr_o = cr_q.nxt;
          if (cr_q.nxt == tail_q) begin
            tail_d = ci_q;
          end else begin
            lk_idx_d = rd.nxt;
            lk_val_d = ci_q;
            lk_next_d = 1'b0;
            lk_ret_d = S_WR_CR;
            state_d = S_LK_RD;
          end
        end
      end
      S_WR_CR: begin
        ram_we_o = 1'b1;
        ram_waddr_o = ci_q;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        done_d = 1'b1;
        out_d.status = status_q;
        out_d.result_address = res_addr_q;
        out_d.moved = moved_q;
        out_d.old_length = old_len_q;
        if (status_q != ST_OK) begin
          out_d.result_address = '0;
          out_d.moved = 1'b0;
          out_d.old_length = '0;
          if (reject_q != '1) begin
            reject_d = reject_q + 1'b1;
          end
        end
        out_d.free_bytes = free_q;
        out_d.error_count = reject_d;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign ram_wdata_o = nw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_idx_q <= '0;
      head_q <= '0;
      tail_q <= '0;
      free_q <= LW'(POOL_BYTES);
      reject_q <= '0;
      done_q <= 1'b0;
      out_q <= '0;
    end else begin
      state_q <= state_d;
      clr_idx_q <= clr_idx_d;
      head_q <= head_d;
      tail_q <= tail_d;
      free_q <= free_d;
      reject_q <= reject_d;
      done_q <= done_d;
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    al_ret_q <= al_ret_d;
    sp_ret_q <= sp_ret_d;
    lk_ret_q <= lk_ret_d;
    cmd_q <= cmd_d;
    addr_q <= addr_d;
    size_q <= size_d;
    cur_q <= cur_d;
    cnt_q <= cnt_d;
    pv_q <= pv_d;
    pidx_q <= pidx_d;
    prec_q <= prec_d;
    ci_q <= ci_d;
    cr_q <= cr_d;
    sp_idx_q <= sp_idx_d;
    lk_idx_q <= lk_idx_d;
    lk_val_q <= lk_val_d;
    lk_next_q <= lk_next_d;
    status_q <= status_d;
    res_addr_q <= res_addr_d;
    moved_q <= moved_d;
    old_len_q <= old_len_d;
  end

  assign busy = (state_q != S_IDLE);
  assign done_o = done_q;
  assign result_o = out_q;

endmodule
`default_nettype wire

// ===== src/segment_pool_allocator.sv =====
// segment pool allocator top level: fit mode register, node ram, sequencer
// depends on spa_pkg, spa_ram, spa_engine and assert_macros.svh
//
// usage: raise start with command_i, block_address_i and request_size_i
// while busy is low; the word is taken at that clock edge. busy stays high
// while the command runs. the result word shows on the result ports with
// done_o high for one cycle, then stays; the receiver cannot hold it off.
// a command walks the address-ordered segment list in the node ram, one node
// at a time: lookup from the list end, fit search over the whole list (first
// fit stops at the first hit), and a scan from node zero for a spare node
// when a split needs one. a command makes at most three walks, plus list
// edits, through the single node ram port pair. one command is in work
// at a time. fit_mode is written with cfg_we_i and cfg_wdata_i; the user
// must write it only while the block is idle: the block does not enforce it.
// after reset the node ram is swept once with busy high, leaving one free
// segment that covers the whole pool.
`default_nettype none
`include "assert_macros.svh"
module segment_pool_allocator #(
  parameter int NODE_COUNT = 1024,
  parameter longint unsigned POOL_BYTES = 33554432
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     start,
  output logic                    busy,
  input  wire [1:0]               command_i,
  input  wire [spa_pkg::AW-1:0]   block_address_i,
  input  wire [spa_pkg::LW-1:0]   request_size_i,
  input  wire                     cfg_we_i,
  input  wire [1:0]               cfg_wdata_i,
  output logic                    done_o,
  output logic [2:0]              status_o,
  output logic [spa_pkg::AW-1:0]  result_address_o,
  output logic                    moved_o,
  output logic [spa_pkg::LW-1:0]  old_length_o,
  output logic [spa_pkg::LW-1:0]  free_bytes_o,
  output logic [spa_pkg::EW-1:0]  error_count_o
);
  import spa_pkg::*;

  localparam int IW = $clog2(NODE_COUNT);
  localparam int NW = AW + LW + 2 + 2 * IW;

  logic [1:0]    fit_q;
  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [NW-1:0] ram_wdata, ram_rdata;
  result_t       res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_q <= FIT_BEST;
    end else if (cfg_we_i) begin
      fit_q <= cfg_wdata_i;
    end
  end

  spa_ram #(
    .WIDTH(NW),
    .DEPTH(NODE_COUNT)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  spa_engine #(
    .NODE_COUNT(NODE_COUNT),
    .POOL_BYTES(POOL_BYTES)
  ) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .block_address_i (block_address_i),
    .request_size_i  (request_size_i),
    .fit_mode_i      (fit_q),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata),
    .done_o          (done_o),
    .result_o        (res)
  );

  assign status_o         = res.status;
  assign result_address_o = res.result_address;
  assign moved_o          = res.moved;
  assign old_length_o     = res.old_length;
  assign free_bytes_o     = res.free_bytes;
  assign error_count_o    = res.error_count;

  `SPA_NEVER(a_done_while_busy, done_o && busy)
  `SPA_ASSERT(a_accept_goes_busy, start && !busy |=> busy)
  `SPA_ASSERT(a_done_one_cycle, done_o |=> !done_o)
  `SPA_ASSERT(a_errcnt_only_on_done, !done_o |=> $stable(error_count_o) || done_o)

endmodule
`default_nettype wire
